// ===== src/imu_ofs_pkg.sv =====
// Shared types, constants and helper functions of the IMU offset calibration block.
`timescale 1ns / 1ps
`default_nettype none

package imu_ofs_pkg;

    // Axis counts and widths.
    localparam int AXES       = 6;
    localparam int AXIS_W     = 16;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 16;
    localparam int AXIS_IDX_W = 3;
    localparam int DIV_STEP_W = 5;
    localparam int RANGE_W    = 2;

    // Axis indexes that the sequencer treats specially.
    localparam logic [AXIS_IDX_W-1:0] AXIS_FIRST = 3'd0;
    localparam logic [AXIS_IDX_W-1:0] AXIS_ACC_Z = 3'd2;
    localparam logic [AXIS_IDX_W-1:0] AXIS_LAST  = 3'd5;

    // Last step of the serial divider: one quotient bit per step.
    localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = DIV_STEP_W'(SUM_W - 1);

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CALIB_SAMPLES = 1'b0;
    localparam t_cfg_idx CFG_ACCEL_RANGE   = 1'b1;
    localparam int       CFG_DATA_W        = 16;

    // Register reset values.
    localparam logic [CNT_W-1:0]   CALIB_SAMPLES_RST = 16'd100;
    localparam logic [RANGE_W-1:0] ACCEL_RANGE_RST   = 2'd0;

    // Item commands.
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CALIB   = 1'b1;

    // Accelerometer full-scale codes.
    localparam logic [RANGE_W-1:0] RANGE_2G  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_4G  = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_8G  = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_16G = 2'd3;

    // Raw count that corresponds to 1 g at each full-scale setting.
    function automatic logic [AXIS_W-1:0] one_g_count(input logic [RANGE_W-1:0] range_code);
        logic [AXIS_W-1:0] count;
        unique case (range_code)
            RANGE_2G:  count = 16'd16384;
            RANGE_4G:  count = 16'd8192;
            RANGE_8G:  count = 16'd4096;
            RANGE_16G: count = 16'd2048;
            default:   count = 16'd16384;
        endcase
        return count;
    endfunction

    // Sample transaction payload.
    typedef struct packed {
        logic                     cmd;
        logic signed [AXIS_W-1:0] acc_x;
        logic signed [AXIS_W-1:0] acc_y;
        logic signed [AXIS_W-1:0] acc_z;
        logic signed [AXIS_W-1:0] rot_x;
        logic signed [AXIS_W-1:0] rot_y;
        logic signed [AXIS_W-1:0] rot_z;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic signed [AXIS_W-1:0] corr_acc_x;
        logic signed [AXIS_W-1:0] corr_acc_y;
        logic signed [AXIS_W-1:0] corr_acc_z;
        logic signed [AXIS_W-1:0] corr_rot_x;
        logic signed [AXIS_W-1:0] corr_rot_y;
        logic signed [AXIS_W-1:0] corr_rot_z;
        logic                     cal_done;
    } t_out_item;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    // Status returned by the divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [AXIS_W-1:0] quot;
    } t_div_stat;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/imu_ofs_if.sv =====
// Valid/ready channel interfaces for sample and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface imu_ofs_in_if;
    logic                  valid;
    logic                  ready;
    imu_ofs_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imu_ofs_out_if;
    logic                   valid;
    logic                   ready;
    imu_ofs_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/imu_ofs_div.sv =====
// Serial restoring divider: signed 32-bit sum by unsigned 16-bit count, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module imu_ofs_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  imu_ofs_pkg::t_div_req  i_req,
    output imu_ofs_pkg::t_div_stat o_stat
);
    import imu_ofs_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]      r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_div;
    logic                  r_neg;

    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_fit;
    logic [CNT_W-1:0] n_rem;
    logic [SUM_W-1:0] w_mag;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
    end

    // Magnitude of the dividend; the sign is restored on the quotient.
    assign w_mag = i_req.dividend[SUM_W-1] ? (~i_req.dividend + SUM_W'(1))
                                           : i_req.dividend;

    // Step counter and datapath. Quotient bits shift in as dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_mag;
                r_div  <= i_req.divisor;
                r_neg  <= i_req.dividend[SUM_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[SUM_W-2:0], w_fit};
                r_cnt <= r_cnt + DIV_STEP_W'(1);
                if (r_cnt == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Truncation toward zero: negate the magnitude quotient for a negative sum.
    always_comb begin
        o_stat.busy = r_busy;
        o_stat.done = r_done;
        o_stat.quot = r_neg ? (~r_quo[AXIS_W-1:0] + AXIS_W'(1)) : r_quo[AXIS_W-1:0];
    end

    // A new division is never started on top of a running one.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    // Completion is a single-cycle pulse and only follows a running division.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a preceding division");

    // A start always leads to a busy divider.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");

endmodule

`default_nettype wire

// ===== src/imu_offset_calibration_core.sv =====
// Top level of the IMU offset calibration block: sample handling, sums, offsets and sequencer.
//
// Usage: sample transactions arrive on i_smp, each carrying a command and six raw axes
// (three accelerometer, three gyro). Every sample gives exactly one result transaction on
// o_res, registered, in the cycle after acceptance. A measure sample returns each axis minus
// its stored offset. A calibration sample adds its axes into 32-bit sums and returns the
// raw axes; the sample that completes a run of calib_samples sets cal_done.
// Throughput: measure samples and ordinary calibration samples are taken one per cycle while
// o_res.ready stays high. After the sample that completes a run, the sequencer feeds the six
// sums in turn through one shared serial divider, one quotient bit per cycle; i_smp.ready
// stays low while the new offsets are computed and written.
// Stalls: the result register holds its transaction until o_res.ready; a new sample is
// only taken when that register is empty or being emptied in the same cycle.
// Reset: offsets zero, no run open, calib_samples 100, accel_range 2 g. Configuration is
// written through i_cfg_we / i_cfg_idx / i_cfg_data and takes effect at once.
`timescale 1ns / 1ps
`default_nettype none

module imu_offset_calibration_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  imu_ofs_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [imu_ofs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    imu_ofs_in_if.sink                               i_smp,
    imu_ofs_out_if.source                            o_res
);
    import imu_ofs_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0]   r_calib_samples;
    logic [RANGE_W-1:0] r_accel_range;

    // Calibration state.
    logic [AXIS_W-1:0]     r_offsets [AXES];
    logic [SUM_W-1:0]      r_sums    [AXES];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_div_n;
    logic [AXIS_W-1:0]     r_one_g;
    logic [AXIS_IDX_W-1:0] r_axis;

    // Sequencer and result register.
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out;

    // Combinational helpers.
    logic signed [AXIS_W-1:0] w_raw  [AXES];
    logic [AXIS_W-1:0]        w_corr [AXES];
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_calib;
    logic                     w_run_start;
    logic                     w_run_end;
    logic [CNT_W:0]           w_n;
    logic [AXIS_W-1:0]        w_z_adj;
    t_div_req                 w_div_req;
    t_div_stat                w_div_stat;

    // Shared divider for the six averages.
    imu_ofs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    // Unpack the sample and decide what kind of transaction it is.
    always_comb begin
        w_raw[0]    = i_smp.data.acc_x;
        w_raw[1]    = i_smp.data.acc_y;
        w_raw[2]    = i_smp.data.acc_z;
        w_raw[3]    = i_smp.data.rot_x;
        w_raw[4]    = i_smp.data.rot_y;
        w_raw[5]    = i_smp.data.rot_z;
        w_out_free  = !r_out_valid || o_res.ready;
        w_accept    = i_smp.valid && i_smp.ready;
        w_calib     = (i_smp.data.cmd == CMD_CALIB);
        w_run_start = w_calib && (r_count == '0);
        w_n         = {1'b0, r_count} + (CNT_W + 1)'(1);
        w_run_end   = w_calib && (w_n >= {1'b0, r_calib_samples});
    end

    // Corrected axes; a run that opens with this sample clears the offsets first.
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_corr[i] = w_run_start ? w_raw[i] : (w_raw[i] - r_offsets[i]);
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_run_end) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = (r_axis == AXIS_LAST) ? ST_IDLE : ST_LOAD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        i_smp.ready        = (r_state == ST_IDLE) && w_out_free;
        w_div_req.start    = (r_state == ST_LOAD);
        w_div_req.dividend = r_sums[r_axis];
        w_div_req.divisor  = r_div_n;
    end

    // The Z accelerometer offset also carries the 1 g count of the range in force.
    assign w_z_adj = (r_axis == AXIS_ACC_Z) ? r_one_g : '0;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_samples <= CALIB_SAMPLES_RST;
            r_accel_range   <= ACCEL_RANGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CALIB_SAMPLES: r_calib_samples <= i_cfg_data[CNT_W-1:0];
                CFG_ACCEL_RANGE:   r_accel_range   <= i_cfg_data[RANGE_W-1:0];
                default:           r_calib_samples <= r_calib_samples;
            endcase
        end
    end

    // Run counter, sums and offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_axis  <= AXIS_FIRST;
            for (int i = 0; i < AXES; i++) begin
                r_offsets[i] <= '0;
            end
        end else begin
            if (w_accept && w_calib) begin
                for (int i = 0; i < AXES; i++) begin
                    r_sums[i] <= (w_run_start ? '0 : r_sums[i]) + SUM_W'(w_raw[i]);
                    if (w_run_start) begin
                        r_offsets[i] <= '0;
                    end
                end
                if (w_run_end) begin
                    r_count <= '0;
                    r_div_n <= w_n[CNT_W-1:0];
                    r_one_g <= one_g_count(r_accel_range);
                    r_axis  <= AXIS_FIRST;
                end else begin
                    r_count <= w_n[CNT_W-1:0];
                end
            end
            if ((r_state == ST_WAIT) && w_div_stat.done) begin
                r_offsets[r_axis] <= w_div_stat.quot - w_z_adj;
                r_axis            <= r_axis + AXIS_IDX_W'(1);
            end
        end
    end

    // Result register: loaded at acceptance, held until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out.corr_acc_x <= w_corr[0];
            r_out.corr_acc_y <= w_corr[1];
            r_out.corr_acc_z <= w_corr[2];
            r_out.corr_rot_x <= w_corr[3];
            r_out.corr_rot_y <= w_corr[4];
            r_out.corr_rot_z <= w_corr[5];
            r_out.cal_done   <= w_run_end;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // No sample is taken while the offsets are being recomputed.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_smp.ready)
        else $error("sample accepted during offset update");

    // The sample that completes a run starts the division sequence from the first axis.
    a_run_end_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_run_end) |=> (r_state == ST_LOAD) && (r_axis == AXIS_FIRST))
        else $error("run end did not start the division sequence");

    // A division is only requested when the shared divider is free.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !w_div_stat.busy && (r_axis <= AXIS_LAST))
        else $error("division requested while divider busy or axis out of range");

    // The result register never drops a transaction the receiver has not taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid && $stable(r_out))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire
